// ===== hw/rtl/lrupr_pkg.sv =====
`default_nettype none
package lrupr_pkg;

  // Frame count register: width and value after reset
  localparam int unsigned CFG_W         = 4;
  localparam int unsigned CFG_RESET_VAL = 3;

  // Fault counter
  localparam int unsigned FCNT_W = 32;
  typedef logic [FCNT_W-1:0] fcnt_t;
  localparam fcnt_t FCNT_MAX = '1;

  // Request from the sequencer to the fault counter
  typedef struct packed {
    logic en;
    logic clr;
  } cnt_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lrupr_frame_mem.sv =====
`default_nettype none
// Page store: one write port, one read port, registered read data.
module lrupr_frame_mem #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned DATA_W = 16,
  parameter int unsigned ADDR_W = 3
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lrupr_fault_ctr.sv =====
`default_nettype none
// Saturating fault counter; the incremented value is offered in the same cycle.
module lrupr_fault_ctr (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lrupr_pkg::cnt_req_t  req,
  output lrupr_pkg::fcnt_t          cnt_upd
);

  lrupr_pkg::fcnt_t cnt_r;
  lrupr_pkg::fcnt_t cnt_nxt;

  always_comb begin
    cnt_upd = cnt_r;
    if (req.en && (cnt_r != lrupr_pkg::FCNT_MAX)) begin
      cnt_upd = cnt_r + lrupr_pkg::fcnt_t'(1);
    end
    cnt_nxt = req.clr ? '0 : cnt_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_never_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cnt_r) == lrupr_pkg::FCNT_MAX && !$past(req.clr)) |-> cnt_r == lrupr_pkg::FCNT_MAX)
    else $error("fault counter wrapped");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/lru_page_replacement.sv =====
`default_nettype none
// LRU page replacement.
// Input channel in_*: one page reference per item; in_tlast marks the last
// reference of a run. After that item's result is formed, all frames and the
// fault count are cleared.
// Output channel out_*: one result item per input item carrying the fault
// flag, the evicted page (when a valid page was evicted) and the running
// saturating fault count.
// Configuration: cfg_wr_en/cfg_wr_data write the frame count (0 acts as 1,
// above FRAMES acts as FRAMES); write only while the block is idle.
// Pages live in a synchronous single-read-port memory in recency order,
// least recent at position 0. An item walks that memory once to search it
// (one entry a cycle, stopping at the first match) and once more to close
// the gap (one entry a cycle), then writes the page at the most recent end.
// A new item can be accepted in the cycle after the result is formed.
// Reset empties all frames, clears the count and sets the frame count to 3.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its final write holds until the receiver takes the result.
module lru_page_replacement #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [PAGE_BITS-1:0] page, rest zero
  input  wire logic [((PAGE_BITS+7)/8)*8-1:0]     in_tdata,
  input  wire logic                               in_tlast,   // end_of_run

  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [0] fault, [1] evicted_valid, [PAGE_BITS+1:2] evicted_page,
  // [PAGE_BITS+33:PAGE_BITS+2] fault_count, rest zero
  output logic [((PAGE_BITS+34+7)/8)*8-1:0]       out_tdata,

  input  wire logic                               cfg_wr_en,
  input  wire logic [lrupr_pkg::CFG_W-1:0]        cfg_wr_data  // frames_in_use
);

  localparam int unsigned OUT_W  = ((PAGE_BITS + 34 + 7) / 8) * 8;
  localparam int unsigned IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
  localparam int unsigned MW     = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_SHIFT, ST_WRITE} state_t;

  state_t                       state_r;
  logic [lrupr_pkg::CFG_W-1:0]  frames_r;
  logic [PAGE_BITS-1:0]         page_r;
  logic                         last_r;
  logic [IDX_W-1:0]             lidx_r;     // most recent position, m-1
  logic [IDX_W-1:0]             ptr_r;      // position whose data arrives now
  logic                         hit_r;
  logic                         ev_valid_r;
  logic [PAGE_BITS-1:0]         ev_page_r;
  logic [FRAMES-1:0]            valid_r;
  logic [FRAMES-1:0]            valid_nxt;

  logic                         out_valid_r;
  logic                         o_fault_r;
  logic                         o_ev_valid_r;
  logic [PAGE_BITS-1:0]         o_ev_page_r;
  lrupr_pkg::fcnt_t             o_count_r;

  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic [PAGE_BITS-1:0]         mem_wdata;
  logic [IDX_W-1:0]             mem_raddr;
  logic [PAGE_BITS-1:0]         mem_rdata;

  logic                         accept;
  logic                         match;
  logic                         at_last;
  logic                         commit;
  logic [IDX_W-1:0]             ptr_inc;
  logic [IDX_W-1:0]             ptr_dec;
  logic [MW-1:0]                m_ext;
  logic [MW-1:0]                m_dec;
  lrupr_pkg::cnt_req_t          cnt_req;
  lrupr_pkg::fcnt_t             cnt_upd;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign ptr_inc   = ptr_r + IDX_W'(1);
  assign ptr_dec   = ptr_r - IDX_W'(1);
  assign match     = valid_r[ptr_r] && (mem_rdata == page_r);
  assign at_last   = (ptr_r == lidx_r);
  assign commit    = (state_r == ST_WRITE) && (!out_valid_r || out_tready);

  // Clamp the frame count into 1..FRAMES
  always_comb begin
    m_ext = MW'(frames_r);
    if (frames_r == '0) begin
      m_ext = MW'(1);
    end else if (m_ext > MW'(FRAMES)) begin
      m_ext = MW'(FRAMES);
    end
    m_dec = m_ext - MW'(1);
  end

  // Read address: next entry in order, entry 1 when a miss starts the shift, else entry 0
  always_comb begin
    mem_raddr = '0;
    if (state_r == ST_SEARCH && !match && at_last) begin
      mem_raddr = IDX_W'(1);
    end else if (state_r == ST_SEARCH || state_r == ST_SHIFT) begin
      mem_raddr = ptr_inc;
    end
  end

  // Write port: close the gap while shifting, place the page at commit
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_dec;
    mem_wdata = mem_rdata;
    if (state_r == ST_SHIFT) begin
      mem_we = 1'b1;
    end else if (commit) begin
      mem_we    = 1'b1;
      mem_waddr = lidx_r;
      mem_wdata = page_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (state_r == ST_SHIFT) begin
      valid_nxt[ptr_dec] = valid_r[ptr_r];
    end else if (commit) begin
      valid_nxt[lidx_r] = 1'b1;
      if (last_r) begin
        valid_nxt = '0;
      end
    end
  end

  assign cnt_req.en  = commit && !hit_r;
  assign cnt_req.clr = commit && last_r;

  lrupr_frame_mem #(
    .DEPTH  (FRAMES),
    .DATA_W (PAGE_BITS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  lrupr_fault_ctr u_ctr (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cnt_req),
    .cnt_upd (cnt_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frames_r    <= lrupr_pkg::CFG_W'(lrupr_pkg::CFG_RESET_VAL);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_wr_en) begin
        frames_r <= cfg_wr_data;
      end
      // Load a new result at commit, otherwise drop the one taken
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (match) begin
            state_r <= at_last ? ST_WRITE : ST_SHIFT;
          end else if (at_last) begin
            state_r <= (lidx_r == '0) ? ST_WRITE : ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (at_last) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (commit) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload, walk pointer, victim and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= in_tdata[PAGE_BITS-1:0];
      last_r <= in_tlast;
      lidx_r <= m_dec[IDX_W-1:0];
      ptr_r  <= '0;
      hit_r  <= 1'b0;
    end
    if (state_r == ST_SEARCH) begin
      if (ptr_r == '0) begin
        // Position 0 is the victim on a miss
        ev_valid_r <= valid_r[0];
        ev_page_r  <= mem_rdata;
      end
      if (match) begin
        hit_r <= 1'b1;
        ptr_r <= ptr_inc;
      end else if (at_last) begin
        ptr_r <= IDX_W'(1);
      end else begin
        ptr_r <= ptr_inc;
      end
    end
    if (state_r == ST_SHIFT) begin
      ptr_r <= ptr_inc;
    end
    if (commit) begin
      o_fault_r    <= !hit_r;
      o_ev_valid_r <= !hit_r && ev_valid_r;
      o_ev_page_r  <= (!hit_r && ev_valid_r) ? ev_page_r : '0;
      o_count_r    <= cnt_upd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({o_count_r, o_ev_page_r, o_ev_valid_r, o_fault_r});

`ifndef SYNTHESIS
  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SEARCH)
    else $error("accepted item did not start a search");
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH || state_r == ST_SHIFT) |-> ptr_r <= lidx_r)
    else $error("walk pointer beyond frame count");
  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (mem_waddr != mem_raddr && ptr_r != '0))
    else $error("shift write collides with read");
  a_evict_implies_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!o_ev_valid_r || o_fault_r))
    else $error("eviction reported without fault");
`endif

endmodule
`default_nettype wire

// ===== tb/lru_page_replacement_chk.sv =====
module lru_page_replacement_chk #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0]      in_tdata,
  input  logic                                in_tlast,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [((PAGE_BITS+34+7)/8)*8-1:0]   out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_wr_data,
  output int                                  refs_outstanding,
  output int                                  mismatch_count,
  output int                                  faults_reported
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OUT_W = ((PAGE_BITS+34+7)/8)*8;

  typedef struct packed {
    logic                 fault;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    lrupr_pkg::fcnt_t     count;
  } lru_result_t;

  // Recency-ordered frame list, least recent at position 0
  logic [PAGE_BITS-1:0]        slot_page  [FRAMES];
  logic                        slot_valid [FRAMES];
  lrupr_pkg::fcnt_t            fault_tally;
  logic [lrupr_pkg::CFG_W-1:0] frame_setting;
  lru_result_t                 expected_q [$];

  initial begin
    refs_outstanding = 0;
    mismatch_count   = 0;
    faults_reported  = 0;
  end

  function automatic void flush_frames();
    for (int k = 0; k < FRAMES; k++) begin
      slot_page[k]  = '0;
      slot_valid[k] = 1'b0;
    end
    fault_tally = '0;
  endfunction

  function automatic lru_result_t reference_page(logic [PAGE_BITS-1:0] pg, logic run_end);
    int unsigned m;
    int unsigned pos;
    logic        found;
    lru_result_t r;
    m = frame_setting;
    if (m < 1) m = 1;
    if (m > FRAMES) m = FRAMES;
    found = 1'b0;
    pos   = 0;
    r     = '0;
    // lowest matching position wins when a page sits in two slots
    for (int unsigned k = 0; k < m; k++) begin
      if (!found && slot_valid[k] && slot_page[k] == pg) begin
        found = 1'b1;
        pos   = k;
      end
    end
    if (!found) begin
      r.fault = 1'b1;
      if (slot_valid[0]) begin
        r.ev_valid = 1'b1;
        r.ev_page  = slot_page[0];
      end
      pos = 0;
      if (fault_tally != lrupr_pkg::FCNT_MAX) fault_tally = fault_tally + 1'b1;
    end
    for (int unsigned k = pos; k + 1 < m; k++) begin
      slot_page[k]  = slot_page[k+1];
      slot_valid[k] = slot_valid[k+1];
    end
    slot_page[m-1]  = pg;
    slot_valid[m-1] = 1'b1;
    r.count = fault_tally;
    if (run_end) flush_frames();
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    lru_result_t exp_r;
    if (!rst_n) begin
      flush_frames();
      frame_setting = lrupr_pkg::CFG_W'(lrupr_pkg::CFG_RESET_VAL);
      expected_q.delete();
    end else begin
      if (cfg_wr_en) frame_setting = cfg_wr_data;
      if (in_tvalid && in_tready)
        expected_q.push_back(reference_page(in_tdata[PAGE_BITS-1:0], in_tlast));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual 0x%0h", $time, out_tdata);
          mismatch_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tdata[0]) faults_reported++;
          compare_field("fault", exp_r.fault, out_tdata[0]);
          compare_field("evicted_valid", exp_r.ev_valid, out_tdata[1]);
          compare_field("evicted_page", exp_r.ev_page, out_tdata[PAGE_BITS+1:2]);
          compare_field("fault_count", exp_r.count, out_tdata[PAGE_BITS+33:PAGE_BITS+2]);
          compare_field("padding", '0, out_tdata[OUT_W-1:PAGE_BITS+34]);
        end
      end
    end
    refs_outstanding = expected_q.size();
  end

endmodule

// ===== tb/lru_page_replacement_tb.sv =====
module lru_page_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAMES    = 8;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned IN_W      = ((PAGE_BITS+7)/8)*8;
  localparam int unsigned OUT_W     = ((PAGE_BITS+34+7)/8)*8;
  localparam int unsigned PHASES    = 9;
  localparam int unsigned PHASE_REFS = 120;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_tvalid   = 1'b0;
  logic                        in_tready;
  logic [IN_W-1:0]             in_tdata    = '0;   // [15:0] page
  logic                        in_tlast    = 1'b0; // end_of_run
  logic                        out_tvalid;
  logic                        out_tready  = 1'b0;
  logic [OUT_W-1:0]            out_tdata;          // [0] fault, [1] evicted_valid,
                                                   // [17:2] evicted_page, [49:18] fault_count
  logic                        cfg_wr_en   = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0] cfg_wr_data = '0;   // frames_in_use

  int refs_outstanding;
  int mismatch_count;
  int faults_reported;

  // Idle percentages for each side, and a request for a long output hold
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          stall_rx    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned refs_sent   = 0;

  always #4 clk = ~clk;

  lru_page_replacement #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lru_page_replacement_chk #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .refs_outstanding(refs_outstanding),
    .mismatch_count  (mismatch_count),
    .faults_reported (faults_reported)
  );

  // Receiver: a long hold, once requested, is counted down here; otherwise
  // drop tready at random by the current idle percentage.
  always @(negedge clk) begin
    if (stall_rx) begin
      stall_rx  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one page reference, called at a falling edge. Return at the falling
  // edge after acceptance with tvalid still high, so that back-to-back items
  // never see tvalid lowered and raised in one step.
  task automatic push_ref(input logic [PAGE_BITS-1:0] pg, input logic run_end);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(pg);
    in_tlast  <= run_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    refs_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid and hold until every outstanding result has been taken.
  task automatic drain_refs();
    in_tvalid <= 1'b0;
    wait (refs_outstanding == 0);
    @(negedge clk);
  endtask

  // Change the frame count only once the block has gone quiet and every result
  // has been taken; then wait before the write.
  task automatic set_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
    drain_refs();
    repeat (20) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int unsigned          frame_plan [PHASES];
    logic [PAGE_BITS-1:0] pool [12];
    logic [PAGE_BITS-1:0] pg;
    int unsigned          eff;
    int unsigned          pool_sz;
    int unsigned          pick;

    frame_plan = '{8, 1, 3, 0, 15, 5, 2, 7, 6};

    // Hold reset, then release it on a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: fill, evict and hit at the reset frame count of three,
    // with the bit extremes of the page field; close the run.
    push_ref(16'h0000, 1'b0);
    push_ref(16'hFFFF, 1'b0);
    push_ref(16'h5555, 1'b0);
    push_ref(16'hAAAA, 1'b0);
    push_ref(16'hFFFF, 1'b0);
    push_ref(16'h5555, 1'b1);

    // Zero frames acts as one
    set_frames(4'd0);
    push_ref(16'h0007, 1'b0);
    push_ref(16'h0007, 1'b0);
    push_ref(16'h0008, 1'b1);

    // Above the built count acts as eight; fill every frame
    set_frames(4'd15);
    for (int k = 0; k < 8; k++) push_ref(PAGE_BITS'(16'h0010 + k), 1'b0);

    // Shrink to three: a page still parked higher up misses and lands again
    set_frames(4'd3);
    push_ref(16'h0015, 1'b0);

    // Grow back: the page now sits in two slots, the lower one must win
    set_frames(4'd8);
    push_ref(16'h0015, 1'b0);
    push_ref(16'hFFFF, 1'b1);

    // Random phases: sender 16 / receiver 85 first, then swapped, then none.
    // Runs carry over from one frame setting to the next unless tlast ends them.
    for (int p = 0; p < PHASES; p++) begin
      set_frames(lrupr_pkg::CFG_W'(frame_plan[p]));
      case (p / 3)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      eff = frame_plan[p];
      if (eff < 1) eff = 1;
      if (eff > FRAMES) eff = FRAMES;
      // A working set a little larger than the frames gives both hits and evictions
      pool_sz = (eff + 3 > 12) ? 12 : eff + 3;
      foreach (pool[k]) pool[k] = PAGE_BITS'($urandom);
      for (int n = 0; n < PHASE_REFS; n++) begin
        if (p == 1 && n == 40) stall_rx = 1'b1;
        if (p == 4 && n == 60) drain_refs();
        pick = $urandom_range(0, 99);
        if (pick < 80)
          pg = pool[$urandom_range(0, pool_sz - 1)];
        else if (pick < 90)
          pg = PAGE_BITS'($urandom);
        else
          pg = ($urandom_range(0, 1) != 0) ? '1 : '0;
        push_ref(pg, $urandom_range(0, 29) == 0);
      end
    end

    // Wait for the last results, then a short settle
    drain_refs();
    repeat (40) @(posedge clk);
    $display("Sent %0d page references over %0d frame settings (0 and 15 included), %0d faults,",
             refs_sent, PHASES + 4, faults_reported);
    $display("with directed hit/evict/duplicate cases, a long output hold and a drain pause.");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #5ms;
    $display("Timeout: %0d results still outstanding", refs_outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
